// File: rtl/sorted_max_priority_queue_top_macros.svh
// Assertion macros shared by the queue checker
`ifndef SORTED_MAX_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_MAX_PRIORITY_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, held off during reset
`define SPQ_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("queue check failed");

// Next-cycle implication, sampled on clk, held off during reset
`define SPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("queue check failed");

`endif

// File: rtl/spq_pkg.sv
// Package: types and codes for the sorted max priority queue
`timescale 1ns / 1ps
package spq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VALUE_W      = 32;
	localparam int COUNT_W      = 5;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [COUNT_W-1:0]        count_t;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_POP    = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// Command broadcast to every cell
	typedef struct packed {
		logic   insert;
		logic   pop;
		value_t value;
	} cmd_t;

endpackage

// File: rtl/spq_req_if.sv
// Interface: request channel carrying one queue operation
`timescale 1ns / 1ps
interface spq_req_if;
	logic            valid;
	logic            ready;
	logic [1:0]      kind;
	spq_pkg::value_t value;

	modport source (output valid, output kind, output value, input ready);
	modport sink (input valid, input kind, input value, output ready);
endinterface

// File: rtl/spq_rsp_if.sv
// Interface: result channel carrying one queue outcome
`timescale 1ns / 1ps
interface spq_rsp_if;
	logic            valid;
	logic            ready;
	spq_pkg::value_t popped_value;
	logic [1:0]      status;
	spq_pkg::count_t count;

	modport source (output valid, output popped_value, output status, output count, input ready);
	modport sink (input valid, input popped_value, input status, input count, output ready);
endinterface

// File: rtl/spq_cell.sv
// One storage cell of the sorted chain: holds one value, shifts or loads it
`timescale 1ns / 1ps
module spq_cell #(
	parameter int INDEX = 0,
	parameter int CNT_W = 5
) (
	input  logic             clk,
	input  spq_pkg::cmd_t    cmd,
	input  logic [CNT_W-1:0] count,
	input  spq_pkg::value_t  left_value,
	input  logic             left_gt,
	input  spq_pkg::value_t  right_value,
	output spq_pkg::value_t  value_q,
	output logic             gt
);
	import spq_pkg::*;

	logic   occupied;
	value_t value_d;

	// Occupied cells above the new value keep their place
	assign occupied = (CNT_W'(INDEX) < count);
	assign gt       = occupied && (value_q > cmd.value);

	// Keep, load the new value at the boundary, or take a neighbour's value
	always_comb begin
		value_d = value_q;
		if (cmd.insert) begin
			if (gt) begin
				value_d = value_q;
			end else if (left_gt) begin
				value_d = cmd.value;
			end else begin
				value_d = left_value;
			end
		end else if (cmd.pop) begin
			value_d = right_value;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

endmodule

// File: rtl/sorted_max_priority_queue_top.sv
// A result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; a held result
// stalls requests only when the result side is not ready.
// Every cell compares and shifts in the same cycle, so the chain length sets no limit.
// Reset clears the fill count and the result valid; cell contents stay as they are.
`timescale 1ns / 1ps
module sorted_max_priority_queue_top #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             accept;
	logic             full;
	logic             empty;
	cmd_t             cmd;
	value_t           cell_value [CAPACITY];
	logic [CAPACITY-1:0] cell_gt;
	logic             rsp_valid_q;
	value_t           popped_q;
	status_t          status_q;
	value_t           popped_d;
	status_t          status_d;
	logic [CNT_W+4:0] count_ext;

	// Request taken whenever the result register is free or being drained
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);

	// Decode the operation into a cell command, popped value, status and new count
	always_comb begin
		cmd.insert = 1'b0;
		cmd.pop    = 1'b0;
		cmd.value  = req.value;
		popped_d   = '0;
		status_d   = STATUS_DONE;
		count_d    = count_q;
		case (req.kind)
			KIND_INSERT: begin
				if (full) begin
					status_d = STATUS_FULL;
				end else begin
					cmd.insert = accept;
					count_d    = count_q + CNT_W'(1);
				end
			end
			KIND_POP: begin
				if (empty) begin
					status_d = STATUS_EMPTY;
				end else begin
					cmd.pop  = accept;
					popped_d = cell_value[0];
					count_d  = count_q - CNT_W'(1);
				end
			end
			KIND_CLEAR: begin
				count_d = '0;
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	// Chain of cells, front cell holds the largest value
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		spq_cell #(
			.INDEX(i),
			.CNT_W(CNT_W)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.count      (count_q),
			.left_value ((i == 0) ? cmd.value : cell_value[(i == 0) ? 0 : i-1]),
			.left_gt    ((i == 0) ? 1'b1 : cell_gt[(i == 0) ? 0 : i-1]),
			.right_value((i == CAPACITY-1) ? cell_value[i] :
				cell_value[(i == CAPACITY-1) ? i : i+1]),
			.value_q    (cell_value[i]),
			.gt         (cell_gt[i])
		);
	end

	// Fill count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
			end
			if (req.ready) begin
				rsp_valid_q <= req.valid;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			popped_q <= popped_d;
			status_q <= status_d;
		end
	end

	assign count_ext        = {5'd0, count_q};
	assign rsp.valid        = rsp_valid_q;
	assign rsp.popped_value = popped_q;
	assign rsp.status       = status_q;
	assign rsp.count        = count_ext[COUNT_W-1:0];

endmodule

// File: rtl/spq_checker.sv
// Checker on the queue ports, bound to the top level
`timescale 1ns / 1ps
`include "sorted_max_priority_queue_top_macros.svh"
module spq_checker #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input spq_pkg::value_t popped_value,
	input logic [1:0]      status,
	input spq_pkg::count_t count
);
	import spq_pkg::*;

	localparam int CNT_EXT_W = spq_pkg::COUNT_W + 32;
	localparam logic [CNT_EXT_W-1:0] CAP_EXT = CNT_EXT_W'(CAPACITY);

	// Every accepted request yields a result in the next cycle
	`SPQ_ASSERT_NEXT(a_req_to_rsp, req_valid && req_ready, rsp_valid)

	// A rejected insert reports a full store
	`SPQ_ASSERT_SAME(a_full_count, rsp_valid && status == STATUS_FULL,
		count == CAP_EXT[COUNT_W-1:0] && popped_value == '0)

	// A pop on empty reports nothing stored and no value
	`SPQ_ASSERT_SAME(a_empty_pop, rsp_valid && status == STATUS_EMPTY,
		count == '0 && popped_value == '0)

	// A stalled result holds
	`SPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
		rsp_valid && $stable(popped_value) && $stable(status) && $stable(count))

endmodule

bind sorted_max_priority_queue_top spq_checker #(
	.CAPACITY(CAPACITY)
) u_spq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.popped_value(rsp.popped_value),
	.status      (rsp.status),
	.count       (rsp.count)
);
